// File: rtl/bscp_pkg.sv
// Package for the charge policy engine: item and config types, command codes,
// screen tracker codes and the fixed policy thresholds. No dependencies.
package bscp_pkg;

    // Command codes carried in s_tuser
    localparam logic [1:0] CMD_EVAL     = 2'd0;
    localparam logic [1:0] CMD_PLUG_IN  = 2'd1;
    localparam logic [1:0] CMD_PLUG_OUT = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_OUTDOOR_EN = 2'd0;
    localparam logic [1:0] CFG_FAST_EN    = 2'd1;
    localparam logic [1:0] CFG_PROTECT_EN = 2'd2;
    localparam logic [1:0] CFG_PROTECT_TH = 2'd3;

    // Screen tracker codes
    localparam logic [1:0] TRK_UNKNOWN   = 2'd0;
    localparam logic [1:0] TRK_BLACK     = 2'd1;
    localparam logic [1:0] TRK_TO_BRIGHT = 2'd2;
    localparam logic [1:0] TRK_BRIGHT    = 2'd3;

    localparam logic [6:0] PROTECT_TH_RESET = 7'd80;

    // Temperatures in tenths of a degree
    localparam logic signed [11:0] PLUG_TEMP_MAX  = 12'sd390;
    localparam logic signed [11:0] FAST_TEMP_CUT  = 12'sd420;
    localparam logic signed [11:0] HOT_TEMP       = 12'sd410;
    localparam logic signed [11:0] WARM_TEMP      = 12'sd380;

    // State of charge limits in percent
    localparam logic [6:0] PLUG_SOC_MAX = 7'd20;
    localparam logic [6:0] FAST_SOC_MAX = 7'd40;
    localparam logic [6:0] HOT_SOC      = 7'd37;
    localparam logic [6:0] WARM_SOC     = 7'd38;
    localparam logic [7:0] PROTECT_HYST = 8'd5;

    // Currents in milliamps
    localparam logic [15:0] FCC_HOT_MIN  = 16'd4300;
    localparam logic [15:0] FCC_CAP_LOW  = 16'd4000;
    localparam logic [15:0] FCC_CAP_HIGH = 16'd4200;

    localparam logic [31:0] BRIGHT_WINDOW_S = 32'd10;

    typedef struct packed {
        logic       outdoor_en;
        logic       fast_en;
        logic       protect_en;
        logic [6:0] protect_th;
    } cfg_t;

    // Classified item: raw fields the back end still needs plus decided compares
    typedef struct packed {
        logic [1:0]  command;
        logic        pps;
        logic        dcp;
        logic        screen_off;
        logic [31:0] now;
        logic [15:0] fcc;
        logic        plug_ok;      // soc and temp allow fast charge if recorded at plug-in
        logic        soc_le40;
        logic        temp_ge420;
        logic        hot_cap;
        logic        warm_cap;
        logic        fcc_ge4300;
        logic        fcc_le4000;
        logic        soc_ge_th;
        logic        soc_gt_th_m5;
        logic        soc_lt_th;
        logic        soc_le_th_m5;
    } item_t;

endpackage

// File: rtl/bscp_front.sv
// Front end of the charge policy engine: unpacks an input beat and classifies
// it into compare flags. Depends on bscp_pkg.
module bscp_front
    import bscp_pkg::*;
(
    input  cfg_t               cfg,
    input  logic [1:0]         command,
    input  logic [6:0]         charge_percent,
    input  logic signed [11:0] temp_dc,
    input  logic               pps_active,
    input  logic               source_is_dcp,
    input  logic               screen_off,
    input  logic [31:0]        now_seconds,
    input  logic [15:0]        thermal_fcc_ma,
    output item_t              item
);

    logic [7:0] soc_plus_hyst;
    logic [7:0] th_wide;

    assign soc_plus_hyst = {1'b0, charge_percent} + PROTECT_HYST;
    assign th_wide       = {1'b0, cfg.protect_th};

    always_comb begin
        item.command      = command;
        item.pps          = pps_active;
        item.dcp          = source_is_dcp;
        item.screen_off   = screen_off;
        item.now          = now_seconds;
        item.fcc          = thermal_fcc_ma;
        item.plug_ok      = (charge_percent <= PLUG_SOC_MAX) && (temp_dc <= PLUG_TEMP_MAX);
        item.soc_le40     = charge_percent <= FAST_SOC_MAX;
        item.temp_ge420   = temp_dc >= FAST_TEMP_CUT;
        item.hot_cap      = (charge_percent > HOT_SOC) && (temp_dc > HOT_TEMP);
        item.warm_cap     = (charge_percent > WARM_SOC) && (temp_dc > WARM_TEMP);
        item.fcc_ge4300   = thermal_fcc_ma >= FCC_HOT_MIN;
        item.fcc_le4000   = thermal_fcc_ma <= FCC_CAP_LOW;
        // soc > th - 5 taken as soc + 5 > th so a small threshold cannot wrap
        item.soc_ge_th    = charge_percent >= cfg.protect_th;
        item.soc_gt_th_m5 = soc_plus_hyst > th_wide;
        item.soc_lt_th    = charge_percent < cfg.protect_th;
        item.soc_le_th_m5 = soc_plus_hyst <= th_wide;
    end

endmodule

// File: rtl/bscp_queue.sv
// Short FIFO of classified items between front and back end.
// Depends on bscp_pkg.
module bscp_queue
    import bscp_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push_valid,
    output logic  push_ready,
    input  item_t push_item,
    output logic  pop_valid,
    input  logic  pop_ready,
    output item_t pop_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t            entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count missed a push");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers differ while empty");

endmodule

// File: rtl/bscp_back.sv
// Charge policy back end: holds policy state, carries out one classified item
// per cycle while no result stalls, and registers its result. Depends on bscp_pkg.
module bscp_back
    import bscp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic        head_valid,
    output logic        head_ready,
    input  item_t       head,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        fast_mode,
    output logic [15:0] fcc_limit_ma,
    output logic        charge_stop,
    output logic        outdoor_active
);

    logic [1:0]  tracker_reg, tracker_next;
    logic [31:0] bright_start_reg, bright_start_next;
    logic        plug_ok_reg, plug_ok_next;
    logic        fast_reg, fast_next;
    logic        protect_reg, protect_next;
    logic        stop_reg, stop_next;
    logic        outdoor_reg, outdoor_next;
    logic [15:0] fcc_res;
    logic [31:0] elapsed;
    logic        pop;

    logic        out_valid_reg;
    logic [15:0] out_fcc_reg;

    assign head_ready = !out_valid_reg || out_ready;
    assign pop        = head_valid && head_ready;
    assign elapsed    = head.now - bright_start_reg;

    always_comb begin
        tracker_next      = tracker_reg;
        bright_start_next = bright_start_reg;
        plug_ok_next      = plug_ok_reg;
        fast_next         = fast_reg;
        protect_next      = protect_reg;
        stop_next         = stop_reg;
        outdoor_next      = outdoor_reg;
        fcc_res           = head.fcc;
        case (head.command)
            CMD_EVAL: begin
                outdoor_next = cfg.outdoor_en && head.dcp;
                // low battery fast charge
                if (!cfg.fast_en) begin
                    fast_next = 1'b0;
                end else begin
                    if (head.pps && plug_ok_reg && head.soc_le40) begin
                        if (head.screen_off) begin
                            tracker_next = TRK_BLACK;
                            fast_next    = 1'b1;
                        end else if (tracker_reg == TRK_UNKNOWN || tracker_reg == TRK_BLACK) begin
                            tracker_next      = TRK_TO_BRIGHT;
                            bright_start_next = head.now;
                            fast_next         = 1'b1;
                        end else begin
                            tracker_next = TRK_BRIGHT;
                            fast_next    = elapsed <= BRIGHT_WINDOW_S;
                        end
                    end
                    if (head.temp_ge420 || !head.soc_le40) begin
                        fast_next = 1'b0;
                    end
                end
                // cool-down cap
                if (fast_next) begin
                    if (head.hot_cap) begin
                        if (head.fcc_ge4300) begin
                            fcc_res = FCC_CAP_LOW;
                        end
                    end else if (head.warm_cap) begin
                        fcc_res = head.fcc_le4000 ? FCC_CAP_LOW : FCC_CAP_HIGH;
                    end
                end
                // long charge protect with hysteresis
                if ((cfg.protect_en && head.soc_ge_th)
                    || (head.soc_gt_th_m5 && head.soc_lt_th && protect_reg)) begin
                    protect_next = 1'b1;
                end else if (((!cfg.protect_en || head.soc_le_th_m5) && protect_reg)
                             || (!cfg.protect_en && !protect_reg)) begin
                    protect_next = 1'b0;
                end
                stop_next = protect_next;
            end
            CMD_PLUG_IN: begin
                plug_ok_next = head.plug_ok;
                stop_next    = 1'b0;
            end
            CMD_PLUG_OUT: begin
                // cleared records of zero percent and zero degrees pass the plug check
                plug_ok_next = 1'b1;
                tracker_next = TRK_UNKNOWN;
                stop_next    = 1'b0;
                protect_next = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tracker_reg      <= TRK_UNKNOWN;
            bright_start_reg <= '0;
            plug_ok_reg      <= 1'b1;
            fast_reg         <= 1'b0;
            protect_reg      <= 1'b0;
            stop_reg         <= 1'b0;
            outdoor_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (pop) begin
                tracker_reg      <= tracker_next;
                bright_start_reg <= bright_start_next;
                plug_ok_reg      <= plug_ok_next;
                fast_reg         <= fast_next;
                protect_reg      <= protect_next;
                stop_reg         <= stop_next;
                outdoor_reg      <= outdoor_next;
                out_valid_reg    <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_fcc_reg <= fcc_res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign fast_mode      = fast_reg;
    assign fcc_limit_ma   = out_fcc_reg;
    assign charge_stop    = stop_reg;
    assign outdoor_active = outdoor_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && head.command == CMD_PLUG_OUT)
        |=> (tracker_reg == TRK_UNKNOWN && !protect_reg && !stop_reg))
        else $error("plug-out left tracker or protect state behind");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && head.command == CMD_EVAL && !cfg.fast_en) |=> !fast_reg)
        else $error("fast mode set with policy disabled");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && head.command == CMD_EVAL) |=> (stop_reg == protect_reg))
        else $error("stop flag diverged from protect state after evaluate");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !pop |=> ($stable(tracker_reg) && $stable(protect_reg) && $stable(plug_ok_reg)))
        else $error("policy state moved without an item");

endmodule

// File: rtl/battery_smart_charge_policy.sv
// Top level of the battery charge policy engine: stream ports, configuration
// registers, and the front end, item queue and back end. Depends on bscp_pkg.
//
// The engine takes one command per input beat (evaluate, plug-in or plug-out)
// and returns exactly one result beat per command, in order. It sustains one
// beat per clock while the result side does not stall: an accepted beat is
// classified at once, sits in a short queue of QUEUE_DEPTH entries, and the
// back end carries it out and registers the result. The policy state update
// in the back end is a loop through its own state registers, which sets the
// one-beat-per-clock rate. When the result side stalls, the queue keeps
// s_tready high until it is full.
// Configuration writes (always accepted) must be made while the engine is
// idle, that is with no result still outstanding. Command code three is
// answered like a plug event but changes no state.
module battery_smart_charge_policy
    import bscp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // charge_percent[6:0], temp_dc[18:7], pps_active[19],
                                   // source_is_dcp[20], screen_off[21], now_seconds[53:22],
                                   // thermal_fcc_ma[69:54], zero[71:70]
    input  logic [1:0]  s_tuser,   // command[1:0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // fast_mode[0], fcc_limit_ma[16:1], charge_stop[17],
                                   // outdoor_active[18], zero[23:19]
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_data
);

    cfg_t  cfg_reg;
    item_t front_item;
    item_t head_item;
    logic  head_valid;
    logic  head_ready;

    logic        fast_mode;
    logic [15:0] fcc_limit_ma;
    logic        charge_stop;
    logic        outdoor_active;

    // Configuration registers; every index is writable, writes never stall
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.outdoor_en <= 1'b0;
            cfg_reg.fast_en    <= 1'b0;
            cfg_reg.protect_en <= 1'b0;
            cfg_reg.protect_th <= PROTECT_TH_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_OUTDOOR_EN: cfg_reg.outdoor_en <= cfg_data[0];
                CFG_FAST_EN:    cfg_reg.fast_en    <= cfg_data[0];
                CFG_PROTECT_EN: cfg_reg.protect_en <= cfg_data[0];
                CFG_PROTECT_TH: cfg_reg.protect_th <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Classify the incoming beat
    bscp_front u_front (
        .cfg            (cfg_reg),
        .command        (s_tuser),
        .charge_percent (s_tdata[6:0]),
        .temp_dc        (s_tdata[18:7]),
        .pps_active     (s_tdata[19]),
        .source_is_dcp  (s_tdata[20]),
        .screen_off     (s_tdata[21]),
        .now_seconds    (s_tdata[53:22]),
        .thermal_fcc_ma (s_tdata[69:54]),
        .item           (front_item)
    );

    // Decouple acceptance from execution
    bscp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (s_tvalid),
        .push_ready (s_tready),
        .push_item  (front_item),
        .pop_valid  (head_valid),
        .pop_ready  (head_ready),
        .pop_item   (head_item)
    );

    // Run the policies and hold the result until taken
    bscp_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .head_valid     (head_valid),
        .head_ready     (head_ready),
        .head           (head_item),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .fast_mode      (fast_mode),
        .fcc_limit_ma   (fcc_limit_ma),
        .charge_stop    (charge_stop),
        .outdoor_active (outdoor_active)
    );

    assign m_tdata = {5'b0, outdoor_active, charge_stop, fcc_limit_ma, fast_mode};

endmodule

// File: bench/charge_policy_monitor.sv
// Result monitor for the charge policy engine: shadows the config registers,
// predicts each result beat from accepted input beats and compares in order.
// Depends on bscp_pkg for command, register and screen tracker codes.
module charge_policy_monitor
    import bscp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [71:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_data,
    output int          fail_count,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIM_PLUG_SOC  = 20;
    localparam int LIM_PLUG_TEMP = 390;
    localparam int LIM_FAST_SOC  = 40;
    localparam int LIM_FAST_TEMP = 420;
    localparam int LIM_HOT_SOC   = 37;
    localparam int LIM_HOT_TEMP  = 410;
    localparam int LIM_WARM_SOC  = 38;
    localparam int LIM_WARM_TEMP = 380;
    localparam int LIM_HOT_FCC   = 4300;
    localparam logic [15:0] FCC_COOL_LOW  = 16'd4000;
    localparam logic [15:0] FCC_COOL_HIGH = 16'd4200;
    localparam int LIM_BRIGHT_S  = 10;
    localparam int LIM_HYST      = 5;

    typedef struct packed {
        logic        fast;
        logic [15:0] fcc;
        logic        stop;
        logic        outdoor;
        logic [4:0]  pad;
    } policy_result_t;

    policy_result_t expected_results[$];

    cfg_t               cfg_shadow;
    logic [6:0]         plug_soc;
    logic signed [11:0] plug_temp;
    logic [1:0]         screen_trk;
    logic [31:0]        bright_t0;
    logic               fast_on;
    logic               protect_on;
    logic               stop_on;
    logic               outdoor_on;

    // Carry out one command on the shadow state and form its result.
    task automatic apply_policy(input logic [1:0] cmd, input logic [71:0] d,
                                output policy_result_t r);
        int          soc;
        int          temp;
        int          th;
        logic        pps;
        logic        dcp;
        logic        scr_off;
        logic [31:0] now;
        logic [31:0] elapsed;
        logic [15:0] fcc;
        soc     = int'(d[6:0]);
        temp    = int'($signed(d[18:7]));
        pps     = d[19];
        dcp     = d[20];
        scr_off = d[21];
        now     = d[53:22];
        fcc     = d[69:54];
        th      = int'(cfg_shadow.protect_th);
        case (cmd)
            CMD_EVAL: begin
                outdoor_on = cfg_shadow.outdoor_en && dcp;
                if (!cfg_shadow.fast_en) begin
                    fast_on = 1'b0;
                end else begin
                    if (pps && plug_soc <= LIM_PLUG_SOC && plug_temp <= LIM_PLUG_TEMP
                        && soc <= LIM_FAST_SOC) begin
                        if (!scr_off && (screen_trk == TRK_UNKNOWN
                                         || screen_trk == TRK_BLACK)) begin
                            screen_trk = TRK_TO_BRIGHT;
                            bright_t0  = now;
                            fast_on    = 1'b1;
                        end else if (!scr_off) begin
                            screen_trk = TRK_BRIGHT;
                            elapsed    = now - bright_t0;
                            fast_on    = (elapsed <= LIM_BRIGHT_S);
                        end else begin
                            screen_trk = TRK_BLACK;
                            fast_on    = 1'b1;
                        end
                    end
                    if (temp >= LIM_FAST_TEMP || soc > LIM_FAST_SOC)
                        fast_on = 1'b0;
                end
                // cool-down cap only while fast charge holds
                if (fast_on) begin
                    if (soc > LIM_HOT_SOC && temp > LIM_HOT_TEMP) begin
                        if (fcc >= LIM_HOT_FCC)
                            fcc = FCC_COOL_LOW;
                    end else if (soc > LIM_WARM_SOC && temp > LIM_WARM_TEMP) begin
                        fcc = (fcc <= FCC_COOL_LOW) ? FCC_COOL_LOW : FCC_COOL_HIGH;
                    end
                end
                // hysteresis compares are signed: th - 5 may go negative
                if ((cfg_shadow.protect_en && soc >= th)
                    || (soc > th - LIM_HYST && soc < th && protect_on))
                    protect_on = 1'b1;
                else if (((!cfg_shadow.protect_en || soc <= th - LIM_HYST) && protect_on)
                         || (!cfg_shadow.protect_en && !protect_on))
                    protect_on = 1'b0;
                stop_on = protect_on;
            end
            CMD_PLUG_IN: begin
                plug_soc  = soc[6:0];
                plug_temp = temp[11:0];
                stop_on   = 1'b0;
            end
            CMD_PLUG_OUT: begin
                plug_soc   = '0;
                plug_temp  = '0;
                screen_trk = TRK_UNKNOWN;
                stop_on    = 1'b0;
                protect_on = 1'b0;
            end
            default: ;
        endcase
        r = '{fast_on, fcc, stop_on, outdoor_on, 5'd0};
    endtask

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (want !== got) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        policy_result_t got;
        policy_result_t want;
        policy_result_t fresh;
        if (!aresetn) begin
            cfg_shadow <= '{1'b0, 1'b0, 1'b0, PROTECT_TH_RESET};
            plug_soc   = '0;
            plug_temp  = '0;
            screen_trk = TRK_UNKNOWN;
            bright_t0  = '0;
            fast_on    = 1'b0;
            protect_on = 1'b0;
            stop_on    = 1'b0;
            outdoor_on = 1'b0;
            expected_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = '{m_tdata[0], m_tdata[16:1], m_tdata[17], m_tdata[18], m_tdata[23:19]};
                if (expected_results.size() == 0) begin
                    fail_count++;
                    $display("%0t: result beat with none expected, actual %h", $time, m_tdata);
                end else begin
                    want = expected_results.pop_front();
                    compare_field("fast_mode", 16'(want.fast), 16'(got.fast));
                    compare_field("fcc_limit_ma", want.fcc, got.fcc);
                    compare_field("charge_stop", 16'(want.stop), 16'(got.stop));
                    compare_field("outdoor_active", 16'(want.outdoor), 16'(got.outdoor));
                    compare_field("pad bits", 16'(want.pad), 16'(got.pad));
                end
            end
            if (s_tvalid && s_tready) begin
                apply_policy(s_tuser, s_tdata, fresh);
                expected_results.push_back(fresh);
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_OUTDOOR_EN: cfg_shadow.outdoor_en <= cfg_data[0];
                    CFG_FAST_EN:    cfg_shadow.fast_en    <= cfg_data[0];
                    CFG_PROTECT_EN: cfg_shadow.protect_en <= cfg_data[0];
                    CFG_PROTECT_TH: cfg_shadow.protect_th <= cfg_data;
                    default: ;
                endcase
            end
        end
        outstanding = expected_results.size();
    end

endmodule

// File: bench/tb.sv
// Testbench top for the charge policy engine: clock, reset, stimulus and verdict.
// Depends on bscp_pkg, battery_smart_charge_policy and charge_policy_monitor.
module tb
    import bscp_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // Fourth command code: the engine answers it but must change no state
    localparam logic [1:0] CMD_RESERVED = 2'd3;
    localparam int LONG_HOLD = 64;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;   // charge_percent[6:0], temp_dc[18:7], pps_active[19],
                            // source_is_dcp[20], screen_off[21], now_seconds[53:22],
                            // thermal_fcc_ma[69:54], zero[71:70]
    logic [1:0]  s_tuser;   // command[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // fast_mode[0], fcc_limit_ma[16:1], charge_stop[17],
                            // outdoor_active[18], zero[23:19]
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [6:0]  cfg_data;

    int          fail_count;
    int          outstanding;

    // Stimulus bookkeeping
    logic        tx_gaps;
    logic        rx_stalls;
    logic        hold_req;
    logic [6:0]  prot_th;
    logic [31:0] now_s;
    logic        scr_dark;
    int          n_accepted;
    int          n_eval;
    int          n_plug;
    int          n_rsvd;
    int          n_settings;

    battery_smart_charge_policy dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    charge_policy_monitor policy_mon (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("tb: FAIL");
        $finish;
    end

    // Result side: draw a stall per beat, and honor one long hold-off on request
    // so the engine's queue fills and it has to drop s_tready.
    initial begin
        int stall;
        bit held;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req && !held) begin
                m_tready = 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                held = 1'b1;
            end
            stall = rx_stalls ? $urandom_range(0, 6) : 0;
            if (stall > 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Offer one beat after an optional gap; leave tvalid high on return so a
    // back-to-back beat never sees it drop.
    task automatic send_beat(input logic [1:0] cmd, input logic [6:0] soc,
                             input logic [11:0] temp, input logic pps, input logic dcp,
                             input logic scr_off, input logic [31:0] now,
                             input logic [15:0] fcc);
        int gap;
        gap = tx_gaps ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  = {2'b00, fcc, now, scr_off, dcp, pps, temp, soc};
        s_tuser  = cmd;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        n_accepted++;
        case (cmd)
            CMD_EVAL:                 n_eval++;
            CMD_PLUG_IN, CMD_PLUG_OUT: n_plug++;
            default:                  n_rsvd++;
        endcase
    endtask

    // Drop tvalid and hold until every expected result has come back.
    task automatic settle();
        s_tvalid = 1'b0;
        while (outstanding != 0) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
        cfg_index = idx;
        cfg_data  = val;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
        if (idx == CFG_PROTECT_TH)
            prot_th = val;
    endtask

    task automatic set_policy(input logic outdoor, input logic fast, input logic protect,
                              input logic [6:0] th);
        settle();
        write_reg(CFG_OUTDOOR_EN, {6'd0, outdoor});
        write_reg(CFG_FAST_EN, {6'd0, fast});
        write_reg(CFG_PROTECT_EN, {6'd0, protect});
        write_reg(CFG_PROTECT_TH, th);
        n_settings++;
    endtask

    // Charge level: mostly in the fast charge band, often near the protect
    // threshold, sometimes anywhere the field allows.
    function automatic logic [6:0] pick_soc();
        int r;
        int v;
        r = $urandom_range(0, 9);
        if (r <= 5)
            v = $urandom_range(0, 45);
        else if (r <= 7)
            v = int'(prot_th) + int'($urandom_range(0, 14)) - 7;
        else if (r == 8)
            v = $urandom_range(0, 100);
        else
            v = $urandom_range(0, 127);
        if (v < 0)
            v = 0;
        if (v > 127)
            v = 127;
        return v[6:0];
    endfunction

    // Temperature: mostly around the cool-down and cutoff thresholds
    function automatic logic [11:0] pick_temp();
        int r;
        int v;
        r = $urandom_range(0, 9);
        if (r <= 5)
            v = int'($urandom_range(0, 70)) + 360;
        else if (r <= 7)
            v = int'($urandom_range(0, 1650)) - 400;
        else
            v = $urandom;
        return v[11:0];
    endfunction

    function automatic logic [15:0] pick_fcc();
        int r;
        int v;
        r = $urandom_range(0, 9);
        if (r <= 4)
            v = $urandom_range(3900, 4400);
        else if (r == 5)
            case ($urandom_range(0, 3))
                0: v = 4000;
                1: v = 4001;
                2: v = 4299;
                default: v = 4300;
            endcase
        else
            v = $urandom;
        return v[15:0];
    endfunction

    // One evaluate beat: advance time a few seconds (or jump anywhere) and
    // flip the screen now and then so the bright window gets exercised.
    task automatic eval_random();
        if ($urandom_range(0, 19) == 0)
            now_s = $urandom;
        else
            now_s = now_s + $urandom_range(0, 4);
        if ($urandom_range(0, 9) < 3)
            scr_dark = ~scr_dark;
        send_beat(CMD_EVAL, pick_soc(), pick_temp(), $urandom_range(0, 7) != 0,
                  1'($urandom_range(0, 1)), scr_dark, now_s, pick_fcc());
    endtask

    task automatic run_phase(input int n_items);
        int          target;
        int          kind;
        logic [6:0]  soc;
        logic [11:0] temp;
        target = n_accepted + n_items;
        while (n_accepted < target) begin
            kind = $urandom_range(0, 99);
            if (kind < 75) begin
                // plug-in with fast-charge-friendly records, a run of evaluates,
                // and usually a plug-out
                soc  = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 127))
                                                    : 7'($urandom_range(0, 22));
                temp = ($urandom_range(0, 4) == 0) ? pick_temp()
                                                    : 12'(int'($urandom_range(200, 395)));
                send_beat(CMD_PLUG_IN, soc, temp, 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), now_s,
                          pick_fcc());
                repeat ($urandom_range(3, 25)) eval_random();
                if ($urandom_range(0, 4) != 0)
                    send_beat(CMD_PLUG_OUT, pick_soc(), pick_temp(), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), now_s,
                              pick_fcc());
            end else if (kind < 90) begin
                repeat ($urandom_range(1, 8)) eval_random();
            end else begin
                // noise: any command, any field value
                send_beat(2'($urandom_range(0, 3)), 7'($urandom), 12'($urandom),
                          1'($urandom), 1'($urandom), 1'($urandom), $urandom,
                          16'($urandom));
            end
        end
    endtask

    initial begin
        logic [6:0] th_list [8];
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = CMD_EVAL;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_OUTDOOR_EN;
        cfg_data     = '0;
        tx_gaps      = 1'b1;
        rx_stalls    = 1'b1;
        hold_req     = 1'b0;
        prot_th      = PROTECT_TH_RESET;
        now_s        = '0;
        scr_dark     = 1'b1;
        n_accepted   = 0;
        n_eval       = 0;
        n_plug       = 0;
        n_rsvd       = 0;
        n_settings   = 0;
        th_list      = '{7'd80, 7'd0, 7'd127, 7'd100, 7'd3, 7'd45, 7'd4, 7'd20};
        th_list[5]   = 7'($urandom_range(5, 99));

        repeat (11) @(negedge aclk);
        aresetn = 1'b1;

        // Directed: every policy path with all features on
        set_policy(1'b1, 1'b1, 1'b1, 7'd80);
        send_beat(CMD_PLUG_IN, 7'd10, 12'd250, 1'b1, 1'b0, 1'b1, 32'd0, 16'd3000);
        // screen dark, then bright, inside then past the window
        send_beat(CMD_EVAL, 7'd10, 12'd250, 1'b1, 1'b0, 1'b1, 32'd100, 16'd3000);
        send_beat(CMD_EVAL, 7'd10, 12'd250, 1'b1, 1'b1, 1'b0, 32'd1000, 16'd3000);
        send_beat(CMD_EVAL, 7'd10, 12'd250, 1'b1, 1'b1, 1'b0, 32'd1010, 16'd3000);
        send_beat(CMD_EVAL, 7'd10, 12'd250, 1'b1, 1'b0, 1'b0, 32'd1011, 16'd3000);
        send_beat(CMD_PLUG_OUT, 7'd0, 12'd0, 1'b0, 1'b0, 1'b1, 32'd1012, 16'd0);
        send_beat(CMD_PLUG_IN, 7'd15, 12'd390, 1'b1, 1'b0, 1'b1, 32'd1999, 16'd3000);
        // hot cap, warm cap low and high, then the temperature and charge cutoffs
        send_beat(CMD_EVAL, 7'd38, 12'd415, 1'b1, 1'b0, 1'b1, 32'd2000, 16'd4300);
        send_beat(CMD_EVAL, 7'd39, 12'd390, 1'b1, 1'b0, 1'b1, 32'd2001, 16'd3000);
        send_beat(CMD_EVAL, 7'd39, 12'd390, 1'b1, 1'b0, 1'b1, 32'd2002, 16'd4100);
        send_beat(CMD_EVAL, 7'd40, 12'd420, 1'b1, 1'b0, 1'b1, 32'd2003, 16'd5000);
        send_beat(CMD_EVAL, 7'd41, 12'd300, 1'b1, 1'b0, 1'b1, 32'd2004, 16'd5000);
        // bright window straddling the wrap of the seconds counter
        send_beat(CMD_PLUG_OUT, 7'd0, 12'd0, 1'b0, 1'b0, 1'b1, 32'd2005, 16'd0);
        send_beat(CMD_PLUG_IN, 7'd0, -12'sd400, 1'b1, 1'b0, 1'b1, 32'd2006, 16'd0);
        send_beat(CMD_EVAL, 7'd0, -12'sd400, 1'b1, 1'b0, 1'b0, 32'hFFFF_FFFA, 16'hFFFF);
        send_beat(CMD_EVAL, 7'd0, -12'sd400, 1'b1, 1'b0, 1'b0, 32'd4, 16'hFFFF);
        send_beat(CMD_EVAL, 7'd0, -12'sd400, 1'b1, 1'b0, 1'b0, 32'd5, 16'd0);
        // protect: trip at threshold, hold inside the hysteresis, release below
        send_beat(CMD_EVAL, 7'd80, 12'd300, 1'b0, 1'b0, 1'b1, 32'd6, 16'd4000);
        send_beat(CMD_EVAL, 7'd76, 12'd300, 1'b0, 1'b0, 1'b1, 32'd7, 16'd4000);
        send_beat(CMD_EVAL, 7'd75, 12'd300, 1'b0, 1'b0, 1'b1, 32'd8, 16'd4000);
        // field extremes and the reserved command
        send_beat(CMD_RESERVED, 7'd127, 12'h7FF, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF, 16'hFFFF);
        send_beat(CMD_EVAL, 7'd127, 12'h800, 1'b1, 1'b1, 1'b1, 32'd0, 16'd0);
        send_beat(CMD_PLUG_IN, 7'd127, 12'h7FF, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF, 16'hFFFF);
        send_beat(CMD_PLUG_OUT, 7'd127, 12'h800, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF, 16'hFFFF);

        // Back pressure: hold the result side while beats keep coming
        tx_gaps  = 1'b0;
        hold_req = 1'b1;
        repeat (12) eval_random();
        hold_req = 1'b0;
        tx_gaps  = 1'b1;

        // Random phases, each under its own register setting and idling mix;
        // the sender drains fully at every boundary before reconfiguring.
        for (int p = 0; p < 8; p++) begin
            tx_gaps   = (p % 4) != 3;
            rx_stalls = !((p % 4) == 2 || p == 7);
            set_policy(p[0], p != 2, (p % 3) != 1, th_list[p]);
            run_phase(135);
        end

        settle();
        repeat (8) @(negedge aclk);
        $display("Covered %0d beats: %0d evaluate, %0d plug, %0d reserved, over %0d settings.",
                 n_accepted, n_eval, n_plug, n_rsvd, n_settings);
        if (fail_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
